[rtl/tsec_pkg.sv]
// shared types and constants for the triangle setup edge corners unit
package tsec_pkg;

	localparam int EDGE_W   = 13;
	localparam int BOX_W    = 12;
	localparam int INV_W    = 32;
	localparam int IDX_W    = 2;
	localparam int CORNER_W = 2;
	localparam int STATUS_W = 2;

	// quotient bits resolved per divider stage
	localparam int DIV_STEPS_PER_STAGE = 4;

	localparam logic [STATUS_W-1:0] STATUS_FRONT = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BACK  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd2;

	localparam logic [CORNER_W-1:0] CORNER_0 = 2'd0;
	localparam logic [CORNER_W-1:0] CORNER_1 = 2'd1;
	localparam logic [CORNER_W-1:0] CORNER_2 = 2'd2;
	localparam logic [CORNER_W-1:0] CORNER_3 = 2'd3;

	localparam logic [IDX_W-1:0] EDGE_FIRST = 2'd0;
	localparam logic [IDX_W-1:0] EDGE_LAST  = 2'd2;

	typedef struct packed {
		logic signed [EDGE_W-1:0] b;
		logic signed [EDGE_W-1:0] c;
		logic [CORNER_W-1:0]      rej;
		logic [CORNER_W-1:0]      acc;
	} edge_info_t;

	typedef struct packed {
		edge_info_t [2:0]        edges;
		logic [STATUS_W-1:0]     status;
		logic signed [BOX_W-1:0] min_x;
		logic signed [BOX_W-1:0] max_x;
		logic signed [BOX_W-1:0] min_y;
		logic signed [BOX_W-1:0] max_y;
	} tri_info_t;

	localparam int M_TDATA_W = IDX_W + 2 * EDGE_W + 2 * CORNER_W + INV_W + 4 * BOX_W;

endpackage

[rtl/triangle_setup_edge_corners_unit.sv]
// triangle setup: edge coefficients, tile corners, bounding box, reciprocal det
//
//  channel  dir  payload
//  s_*      in   tdata: x0, y0, x1, y1, x2, y2 (COORD_WIDTH each)
//  m_*      out  tdata: edge_index, edge_b, edge_c, reject_corner, accept_corner,
//                inv_det, min_x, max_x, min_y, max_y; tuser: status; tlast: last
//
//  a triangle enters the pipeline every cycle while s_tready is high; the output
//  register then needs three beats per triangle (one for a degenerate one), and it
//  takes the next triangle only as the last beat of the current one is sent
//  the divider stages resolve up to four quotient bits each
//  reset clears only the valid bits and the output edge index; a stall freezes all stages together
module triangle_setup_edge_corners_unit #(
	parameter int COORD_WIDTH     = 16,
	parameter int COORD_FRAC_BITS = 4,
	parameter int INV_FRAC_BITS   = 30
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// x0, y0, x1, y1, x2, y2
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]           s_tdata,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// edge_index, edge_b, edge_c, reject_corner, accept_corner, inv_det,
	// min_x, max_x, min_y, max_y
	output logic [tsec_pkg::M_TDATA_W-1:0]               m_tdata,
	// status
	output logic [tsec_pkg::STATUS_W-1:0]                m_tuser,
	output logic                                         m_tlast
);
	import tsec_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int BW = CW + 1 - COORD_FRAC_BITS;
	localparam int DW = 2 * BW + 1;

	logic                    adv;
	logic signed [CW-1:0]    x [3];
	logic signed [CW-1:0]    y [3];

	logic                    d_valid;
	logic signed [BW-1:0]    d_b [3];
	logic signed [BW-1:0]    d_c [3];
	logic signed [BOX_W-1:0] d_min_x, d_max_x, d_min_y, d_max_y;

	logic                    t_valid;
	tri_info_t               t_info;
	logic [DW-1:0]           t_mag;
	logic                    t_neg;

	logic                    r_valid;
	tri_info_t               r_info;
	logic signed [INV_W-1:0] r_inv;

	logic                    e_ready;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			x[k] = s_tdata[2*k*CW +: CW];
			y[k] = s_tdata[(2*k+1)*CW +: CW];
		end
	end

	assign adv      = e_ready || !r_valid;
	assign s_tready = adv;

	tsec_delta #(
		.CW (CW),
		.FB (COORD_FRAC_BITS)
	) u_delta (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.x         (x),
		.y         (y),
		.out_valid (d_valid),
		.b         (d_b),
		.c         (d_c),
		.min_x     (d_min_x),
		.max_x     (d_max_x),
		.min_y     (d_min_y),
		.max_y     (d_max_y)
	);

	tsec_det #(
		.BW (BW)
	) u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (d_valid),
		.b         (d_b),
		.c         (d_c),
		.min_x     (d_min_x),
		.max_x     (d_max_x),
		.min_y     (d_min_y),
		.max_y     (d_max_y),
		.out_valid (t_valid),
		.info      (t_info),
		.mag       (t_mag),
		.neg       (t_neg)
	);

	tsec_recip #(
		.DW  (DW),
		.IFB (INV_FRAC_BITS)
	) u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (t_valid),
		.in_info   (t_info),
		.mag       (t_mag),
		.neg       (t_neg),
		.out_valid (r_valid),
		.out_info  (r_info),
		.inv       (r_inv)
	);

	tsec_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (r_valid),
		.in_info  (r_info),
		.in_inv   (r_inv),
		.in_ready (e_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[rtl/tsec_delta.sv]
// edge deltas and bounding box, truncated toward zero (stages 1 and 2)
module tsec_delta #(
	parameter int CW = 16,
	parameter int FB = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic signed [CW-1:0]              x [3],
	input  logic signed [CW-1:0]              y [3],
	output logic                              out_valid,
	output logic signed [CW-FB:0]             b [3],
	output logic signed [CW-FB:0]             c [3],
	output logic signed [tsec_pkg::BOX_W-1:0] min_x,
	output logic signed [tsec_pkg::BOX_W-1:0] max_x,
	output logic signed [tsec_pkg::BOX_W-1:0] min_y,
	output logic signed [tsec_pkg::BOX_W-1:0] max_y
);
	import tsec_pkg::*;

	localparam int BW = CW + 1 - FB;
	localparam logic signed [CW:0]   DBIAS = (CW + 1)'(2 ** FB - 1);
	localparam logic signed [CW-1:0] CBIAS = CW'(2 ** FB - 1);
	localparam logic signed [CW:0]   DZERO = '0;
	localparam logic signed [CW-1:0] CZERO = '0;

	logic                 v_s1;
	logic signed [CW:0]   dx_s1 [3];
	logic signed [CW:0]   dy_s1 [3];
	logic signed [CW-1:0] lo_x_s1, hi_x_s1, lo_y_s1, hi_y_s1;

	logic signed [CW:0]   dx_d [3];
	logic signed [CW:0]   dy_d [3];
	logic signed [CW-1:0] mx_lo, mx_hi, my_lo, my_hi;
	logic signed [CW-1:0] lo_x_d, hi_x_d, lo_y_d, hi_y_d;

	logic                 v_s2;
	logic signed [BW-1:0] b_s2 [3];
	logic signed [BW-1:0] c_s2 [3];
	logic signed [BOX_W-1:0] min_x_s2, max_x_s2, min_y_s2, max_y_s2;

	logic signed [BW-1:0]    b_d [3];
	logic signed [BW-1:0]    c_d [3];
	logic signed [BOX_W-1:0] min_x_d, max_x_d, min_y_d, max_y_d;

	// stage 1: raw deltas per edge and box extremes
	always_comb begin
		dx_d[0] = (CW + 1)'(x[1]) - (CW + 1)'(x[0]);
		dx_d[1] = (CW + 1)'(x[2]) - (CW + 1)'(x[1]);
		dx_d[2] = (CW + 1)'(x[0]) - (CW + 1)'(x[2]);
		dy_d[0] = (CW + 1)'(y[1]) - (CW + 1)'(y[0]);
		dy_d[1] = (CW + 1)'(y[2]) - (CW + 1)'(y[1]);
		dy_d[2] = (CW + 1)'(y[0]) - (CW + 1)'(y[2]);
		mx_lo  = (x[0] < x[1]) ? x[0] : x[1];
		mx_hi  = (x[0] > x[1]) ? x[0] : x[1];
		my_lo  = (y[0] < y[1]) ? y[0] : y[1];
		my_hi  = (y[0] > y[1]) ? y[0] : y[1];
		lo_x_d = (mx_lo < x[2]) ? mx_lo : x[2];
		hi_x_d = (mx_hi > x[2]) ? mx_hi : x[2];
		lo_y_d = (my_lo < y[2]) ? my_lo : y[2];
		hi_y_d = (my_hi > y[2]) ? my_hi : y[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1   <= dx_d;
			dy_s1   <= dy_d;
			lo_x_s1 <= lo_x_d;
			hi_x_s1 <= hi_x_d;
			lo_y_s1 <= lo_y_d;
			hi_y_s1 <= hi_y_d;
		end
	end

	// stage 2: drop fraction bits, rounding toward zero
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			b_d[k] = BW'((dy_s1[k] + (dy_s1[k][CW] ? DBIAS : DZERO)) >>> FB);
			c_d[k] = BW'((dx_s1[k] + (dx_s1[k][CW] ? DBIAS : DZERO)) >>> FB);
		end
		min_x_d = BOX_W'((lo_x_s1 + (lo_x_s1[CW-1] ? CBIAS : CZERO)) >>> FB);
		max_x_d = BOX_W'((hi_x_s1 + (hi_x_s1[CW-1] ? CBIAS : CZERO)) >>> FB);
		min_y_d = BOX_W'((lo_y_s1 + (lo_y_s1[CW-1] ? CBIAS : CZERO)) >>> FB);
		max_y_d = BOX_W'((hi_y_s1 + (hi_y_s1[CW-1] ? CBIAS : CZERO)) >>> FB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s2     <= b_d;
			c_s2     <= c_d;
			min_x_s2 <= min_x_d;
			max_x_s2 <= max_x_d;
			min_y_s2 <= min_y_d;
			max_y_s2 <= max_y_d;
		end
	end

	assign out_valid = v_s2;
	assign b         = b_s2;
	assign c         = c_s2;
	assign min_x     = min_x_s2;
	assign max_x     = max_x_s2;
	assign min_y     = min_y_s2;
	assign max_y     = max_y_s2;

endmodule

[rtl/tsec_det.sv]
// determinant, orientation fix and tile corner selection (stages 3 to 5)
module tsec_det #(
	parameter int BW = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic signed [BW-1:0]              b [3],
	input  logic signed [BW-1:0]              c [3],
	input  logic signed [tsec_pkg::BOX_W-1:0] min_x,
	input  logic signed [tsec_pkg::BOX_W-1:0] max_x,
	input  logic signed [tsec_pkg::BOX_W-1:0] min_y,
	input  logic signed [tsec_pkg::BOX_W-1:0] max_y,
	output logic                              out_valid,
	output tsec_pkg::tri_info_t               info,
	output logic [2*BW:0]                     mag,
	output logic                              neg
);
	import tsec_pkg::*;

	localparam int DW = 2 * BW + 1;

	logic                    v_s3;
	logic signed [2*BW-1:0]  p1_s3, p2_s3;
	logic signed [BW-1:0]    b_s3 [3];
	logic signed [BW-1:0]    c_s3 [3];
	logic signed [BOX_W-1:0] box_s3 [4];

	logic                    v_s4;
	logic signed [DW-1:0]    det_s4;
	logic signed [BW-1:0]    b_s4 [3];
	logic signed [BW-1:0]    c_s4 [3];
	logic signed [BOX_W-1:0] box_s4 [4];

	logic                    v_s5;
	tri_info_t               info_s5;
	logic [DW-1:0]           mag_s5;
	logic                    neg_s5;

	tri_info_t               info_d;
	logic [DW-1:0]           mag_d;
	logic                    neg_d;
	logic                    zero_d;
	logic signed [BW-1:0]    bf, cf;
	logic                    nx, ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 3: the two cross products
	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s3     <= (2 * BW)'(c[2]) * (2 * BW)'(b[1]);
			p2_s3     <= (2 * BW)'(c[1]) * (2 * BW)'(b[2]);
			b_s3      <= b;
			c_s3      <= c;
			box_s3[0] <= min_x;
			box_s3[1] <= max_x;
			box_s3[2] <= min_y;
			box_s3[3] <= max_y;
		end
	end

	// stage 4: det = c1*b2 - c2*b1
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= DW'(p2_s3) - DW'(p1_s3);
			b_s4   <= b_s3;
			c_s4   <= c_s3;
			box_s4 <= box_s3;
		end
	end

	// stage 5: sign fix, corners, status
	always_comb begin
		neg_d  = det_s4[DW-1];
		zero_d = (det_s4 == '0);
		mag_d  = neg_d ? DW'(-det_s4) : DW'(det_s4);
		info_d = '0;
		for (int k = 0; k < 3; k++) begin
			bf = neg_d ? -b_s4[k] : b_s4[k];
			cf = neg_d ? -c_s4[k] : c_s4[k];
			nx = bf[BW-1];
			ny = !cf[BW-1] && (cf != '0);
			info_d.edges[k].b = EDGE_W'(bf);
			info_d.edges[k].c = EDGE_W'(cf);
			case ({nx, ny})
				2'b11: begin
					info_d.edges[k].rej = CORNER_3;
					info_d.edges[k].acc = CORNER_0;
				end
				2'b10: begin
					info_d.edges[k].rej = CORNER_1;
					info_d.edges[k].acc = CORNER_2;
				end
				2'b01: begin
					info_d.edges[k].rej = CORNER_2;
					info_d.edges[k].acc = CORNER_1;
				end
				default: begin
					info_d.edges[k].rej = CORNER_0;
					info_d.edges[k].acc = CORNER_3;
				end
			endcase
		end
		if (zero_d) begin
			info_d.edges  = '0;
			info_d.status = STATUS_DEGEN;
		end else if (neg_d) begin
			info_d.status = STATUS_BACK;
		end else begin
			info_d.status = STATUS_FRONT;
		end
		info_d.min_x = box_s4[0];
		info_d.max_x = box_s4[1];
		info_d.min_y = box_s4[2];
		info_d.max_y = box_s4[3];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			info_s5 <= info_d;
			mag_s5  <= mag_d;
			neg_s5  <= neg_d;
		end
	end

	assign out_valid = v_s5;
	assign info      = info_s5;
	assign mag       = mag_s5;
	assign neg       = neg_s5;

endmodule

[rtl/tsec_recip.sv]
// pipelined restoring divider for 2^IFB / |det|, up to DIV_STEPS_PER_STAGE quotient bits per stage
module tsec_recip #(
	parameter int DW  = 27,
	parameter int IFB = 30
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  tsec_pkg::tri_info_t               in_info,
	input  logic [DW-1:0]                     mag,
	input  logic                              neg,
	output logic                              out_valid,
	output tsec_pkg::tri_info_t               out_info,
	output logic signed [tsec_pkg::INV_W-1:0] inv
);
	import tsec_pkg::*;

	localparam int QW  = IFB + 1;
	localparam int RW  = DW + 1;
	localparam int SPS = DIV_STEPS_PER_STAGE;
	localparam int NS  = (QW + SPS - 1) / SPS;

	logic            v_s    [0:NS];
	tri_info_t       info_s [0:NS];
	logic            neg_s  [0:NS];
	logic [QW-1:0]   q_s    [0:NS];
	logic [RW-1:0]   rem_s  [0:NS-1];
	logic [DW-1:0]   mag_s  [0:NS-1];

	logic signed [QW:0] qs;

	assign v_s[0]    = in_valid;
	assign info_s[0] = in_info;
	assign neg_s[0]  = neg;
	assign q_s[0]    = '0;
	assign rem_s[0]  = '0;
	assign mag_s[0]  = mag;

	for (genvar st = 0; st < NS; st++) begin : g_stage
		logic [RW-1:0] rem_d;
		logic [QW-1:0] q_d;

		// numerator is a single one followed by zeros
		always_comb begin
			rem_d = rem_s[st];
			q_d   = q_s[st];
			for (int i = 0; i < SPS; i++) begin
				if (st * SPS + i < QW) begin
					rem_d = {rem_d[RW-2:0], (st * SPS + i == 0) ? 1'b1 : 1'b0};
					q_d   = {q_d[QW-2:0], 1'b0};
					if (rem_d >= {1'b0, mag_s[st]}) begin
						rem_d  = rem_d - {1'b0, mag_s[st]};
						q_d[0] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[st+1] <= 1'b0;
			end else if (adv) begin
				v_s[st+1] <= v_s[st];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				info_s[st+1] <= info_s[st];
				neg_s[st+1]  <= neg_s[st];
				q_s[st+1]    <= q_d;
			end
		end

		if (st + 1 < NS) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[st+1] <= rem_d;
					mag_s[st+1] <= mag_s[st];
				end
			end
		end
	end

	always_comb begin
		qs  = signed'({1'b0, q_s[NS]});
		qs  = neg_s[NS] ? -qs : qs;
		inv = INV_W'(qs);
	end

	assign out_valid = v_s[NS];
	assign out_info  = info_s[NS];

endmodule

[rtl/tsec_emit.sv]
// output register that sends one beat per edge, or one for a degenerate triangle
module tsec_emit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  tsec_pkg::tri_info_t                   in_info,
	input  logic signed [tsec_pkg::INV_W-1:0]     in_inv,
	output logic                                  in_ready,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [tsec_pkg::M_TDATA_W-1:0]        m_tdata,
	output logic [tsec_pkg::STATUS_W-1:0]         m_tuser,
	output logic                                  m_tlast
);
	import tsec_pkg::*;

	logic                    busy_q;
	logic [IDX_W-1:0]        idx_q;
	tri_info_t               info_q;
	logic signed [INV_W-1:0] inv_q;

	edge_info_t              cur;
	logic                    last_beat;
	logic                    fire;
	logic                    load;

	assign last_beat = (idx_q == EDGE_LAST) || (info_q.status == STATUS_DEGEN);
	assign fire      = busy_q && m_tready;
	assign in_ready  = !busy_q || (m_tready && last_beat);
	assign load      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= EDGE_FIRST;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= EDGE_FIRST;
		end else if (fire) begin
			if (last_beat) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			info_q <= in_info;
			inv_q  <= (in_info.status == STATUS_DEGEN) ? '0 : in_inv;
		end
	end

	always_comb begin
		case (idx_q)
			2'd1:    cur = info_q.edges[1];
			2'd2:    cur = info_q.edges[2];
			default: cur = info_q.edges[0];
		endcase
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = last_beat;
	assign m_tuser  = info_q.status;
	assign m_tdata  = {info_q.max_y, info_q.min_y, info_q.max_x, info_q.min_x, inv_q,
		cur.acc, cur.rej, cur.c, cur.b, idx_q};

endmodule
